/* sv/gbr_pkg.sv */
// ----------------------------------------------------------------------------
// Glyph bitmap rasterizer package
// Shared widths, register indexes, reset values, sequencer states and the
// glyph size check used by the rasterizer and its channel interfaces.
// ----------------------------------------------------------------------------
package gbr_pkg;

   // Default coordinate width of the pixel grid.
   localparam int DEFAULT_COORD_BITS = 12;

   // Fixed field widths.
   localparam int SIZE_BITS      = 6;
   localparam int COLOR_BITS     = 16;
   localparam int SCREEN_BITS    = 13;
   localparam int BYTE_BITS      = 8;
   localparam int BIT_IDX_BITS   = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GLYPH_SIZE    = 3'd0,
      CSR_GLYPH_KIND    = 3'd1,
      CSR_FORE_COLOR    = 3'd2,
      CSR_BACK_COLOR    = 3'd3,
      CSR_BACK_ENABLE   = 3'd4,
      CSR_SCREEN_WIDTH  = 3'd5,
      CSR_SCREEN_HEIGHT = 3'd6
   } csr_index_type;

   // Glyph kinds.
   localparam logic KIND_DOUBLE_BYTE = 1'b0;
   localparam logic KIND_ASCII       = 1'b1;

   // Register reset values.
   localparam logic [SIZE_BITS-1:0]   GLYPH_SIZE_RESET    = 6'd16;
   localparam logic                   GLYPH_KIND_RESET    = KIND_DOUBLE_BYTE;
   localparam logic [COLOR_BITS-1:0]  FORE_COLOR_RESET    = 16'hFFFF;
   localparam logic [COLOR_BITS-1:0]  BACK_COLOR_RESET    = 16'h0000;
   localparam logic                   BACK_ENABLE_RESET   = 1'b1;
   localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd320;
   localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd240;

   // The 8-pixel glyph stores its bits LSB first.
   localparam logic [SIZE_BITS-1:0] LSB_FIRST_SIZE = 6'd8;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   // A glyph size is drawn only if it is one of the supported heights; the
   // 8-pixel height exists only for ASCII glyphs.
   function automatic logic size_legal(input logic [SIZE_BITS-1:0] size,
                                       input logic                 kind);
      logic legal;
      legal = (size inside {6'd12, 6'd16, 6'd24, 6'd32}) ||
              ((kind == KIND_ASCII) && (size == LSB_FIRST_SIZE));
      return legal;
   endfunction

endpackage

/* sv/glyph_req_if.sv */
// ----------------------------------------------------------------------------
// Glyph request channel
// Valid/ready channel that carries one glyph bitmap byte per beat, with the
// glyph start flag and start coordinates.
// ----------------------------------------------------------------------------
interface glyph_req_if
   import gbr_pkg::*;
#(
   parameter int COORD_BITS = DEFAULT_COORD_BITS
);
   logic                  valid;
   logic                  ready;
   logic                  glyph_start;
   logic [COORD_BITS-1:0] start_col;
   logic [COORD_BITS-1:0] start_row;
   logic [BYTE_BITS-1:0]  bitmap_byte;

   modport source (
      output valid, glyph_start, start_col, start_row, bitmap_byte,
      input  ready
   );

   modport sink (
      input  valid, glyph_start, start_col, start_row, bitmap_byte,
      output ready
   );
endinterface

/* sv/glyph_rsp_if.sv */
// ----------------------------------------------------------------------------
// Glyph pixel channel
// Valid/ready channel that carries one pixel write per beat: position,
// color and a flag on the final pixel of a bitmap byte.
// ----------------------------------------------------------------------------
interface glyph_rsp_if
   import gbr_pkg::*;
#(
   parameter int COORD_BITS = DEFAULT_COORD_BITS
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_col;
   logic [COORD_BITS-1:0] pixel_row;
   logic [COLOR_BITS-1:0] pixel_color;
   logic                  last_of_byte;

   modport source (
      output valid, pixel_col, pixel_row, pixel_color, last_of_byte,
      input  ready
   );

   modport sink (
      input  valid, pixel_col, pixel_row, pixel_color, last_of_byte,
      output ready
   );
endinterface

/* sv/glyph_bitmap_rasterizer.sv */
// ----------------------------------------------------------------------------
// Glyph bitmap rasterizer
// Expands column-major glyph bitmap bytes into pixel writes.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on req_chan carries one bitmap byte. A beat with glyph_start set
// also loads the start column and row and opens a new glyph. Every byte
// expands to up to eight pixel beats on rsp_chan; last_of_byte marks the
// final pixel of a byte, and a byte that draws nothing gives no beat.
// One step unit walks the byte one bit per cycle unless rsp_chan stalls it:
// row address, bit pick, row and column advance and the ASCII edge checks.
// A byte is accepted in ST_IDLE, walked in ST_RUN (up to eight bits) and its
// final pixel is released in ST_FLUSH. Each pixel waits in the hold register
// until the next one is known, then passes to the output register that
// drives rsp_chan. req_chan.ready is high only while the sequencer is idle.
// A stall on rsp_chan freezes the step unit when it has a pixel to push out;
// nothing is dropped. Configuration registers are written through csr_* one
// per cycle; the user must do so only while the block is idle, which the
// block itself does not enforce. A synchronous reset restores the register
// defaults and leaves the glyph stopped until a beat with glyph_start arrives.
// ----------------------------------------------------------------------------
module glyph_bitmap_rasterizer
   import gbr_pkg::*;
#(
   parameter int COORD_BITS = DEFAULT_COORD_BITS
)
(
   input  logic                      clock,
   input  logic                      reset,
   glyph_req_if.sink                 req_chan,
   glyph_rsp_if.source               rsp_chan,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int CMP_BITS = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

   // Configuration registers.
   logic [SIZE_BITS-1:0]   glyph_size_ff;
   logic                   glyph_kind_ff;
   logic [COLOR_BITS-1:0]  fore_color_ff;
   logic [COLOR_BITS-1:0]  back_color_ff;
   logic                   back_enable_ff;
   logic [SCREEN_BITS-1:0] screen_width_ff;
   logic [SCREEN_BITS-1:0] screen_height_ff;

   // Glyph walk state.
   logic [COORD_BITS-1:0]   cur_col_ff, cur_col_in;
   logic [COORD_BITS-1:0]   origin_row_ff, origin_row_in;
   logic [SIZE_BITS-1:0]    row_offset_ff, row_offset_in;
   logic                    stopped_ff, stopped_in;

   // Sequencer.
   state_type               state_ff, state_in;
   logic [BIT_IDX_BITS-1:0] bit_cnt_ff, bit_cnt_in;
   logic [BYTE_BITS-1:0]    byte_ff, byte_in;

   // Hold register for the newest pixel.
   logic                    hold_valid_ff, hold_valid_in;
   logic [COORD_BITS-1:0]   hold_col_ff, hold_col_in;
   logic [COORD_BITS-1:0]   hold_row_ff, hold_row_in;
   logic [COLOR_BITS-1:0]   hold_color_ff, hold_color_in;

   // Output register.
   logic                    out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0]   out_col_ff, out_col_in;
   logic [COORD_BITS-1:0]   out_row_ff, out_row_in;
   logic [COLOR_BITS-1:0]   out_color_ff, out_color_in;
   logic                    out_last_ff, out_last_in;

   // Step unit signals.
   logic                    slot_free;
   logic [BIT_IDX_BITS-1:0] bit_idx;
   logic                    bit_set;
   logic                    emit;
   logic [COORD_BITS-1:0]   pix_row;
   logic [SIZE_BITS-1:0]    offset_next;
   logic [COORD_BITS-1:0]   row_next;
   logic [COORD_BITS-1:0]   col_next;
   logic                    row_stop;
   logic                    col_wrap;
   logic                    col_stop;

   assign slot_free  = !out_valid_ff || rsp_chan.ready;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_size_ff    <= GLYPH_SIZE_RESET;
         glyph_kind_ff    <= GLYPH_KIND_RESET;
         fore_color_ff    <= FORE_COLOR_RESET;
         back_color_ff    <= BACK_COLOR_RESET;
         back_enable_ff   <= BACK_ENABLE_RESET;
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_GLYPH_SIZE:    glyph_size_ff    <= csr_write_data[SIZE_BITS-1:0];
            CSR_GLYPH_KIND:    glyph_kind_ff    <= csr_write_data[0];
            CSR_FORE_COLOR:    fore_color_ff    <= csr_write_data[COLOR_BITS-1:0];
            CSR_BACK_COLOR:    back_color_ff    <= csr_write_data[COLOR_BITS-1:0];
            CSR_BACK_ENABLE:   back_enable_ff   <= csr_write_data[0];
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_write_data[SCREEN_BITS-1:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_write_data[SCREEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Step unit: one bitmap bit, its pixel and the row and column advance.
   always_comb begin
      bit_idx     = (glyph_size_ff == LSB_FIRST_SIZE) ? bit_cnt_ff : ~bit_cnt_ff;
      bit_set     = byte_ff[bit_idx];
      emit        = bit_set || back_enable_ff;
      pix_row     = origin_row_ff + COORD_BITS'(row_offset_ff);
      offset_next = row_offset_ff + SIZE_BITS'(1);
      row_next    = origin_row_ff + COORD_BITS'(offset_next);
      col_next    = cur_col_ff + COORD_BITS'(1);
      row_stop    = (glyph_kind_ff == KIND_ASCII) &&
                    (CMP_BITS'(row_next) >= CMP_BITS'(screen_height_ff));
      col_wrap    = offset_next >= glyph_size_ff;
      col_stop    = (glyph_kind_ff == KIND_ASCII) &&
                    (CMP_BITS'(col_next) >= CMP_BITS'(screen_width_ff));
   end

   // Sequencer: next state and register inputs.
   always_comb begin
      state_in      = state_ff;
      bit_cnt_in    = bit_cnt_ff;
      byte_in       = byte_ff;
      cur_col_in    = cur_col_ff;
      origin_row_in = origin_row_ff;
      row_offset_in = row_offset_ff;
      stopped_in    = stopped_ff;
      hold_valid_in = hold_valid_ff;
      hold_col_in   = hold_col_ff;
      hold_row_in   = hold_row_ff;
      hold_color_in = hold_color_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      out_color_in  = out_color_ff;
      out_last_in   = out_last_ff;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // Ready is always high here, so a valid beat is accepted.
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               byte_in    = req_chan.bitmap_byte;
               bit_cnt_in = '0;
               if (req_chan.glyph_start) begin
                  cur_col_in    = req_chan.start_col;
                  origin_row_in = req_chan.start_row;
                  row_offset_in = '0;
                  stopped_in    = 1'b0;
               end
               if ((req_chan.glyph_start || !stopped_ff) &&
                   size_legal(glyph_size_ff, glyph_kind_ff)) begin
                  state_in = ST_RUN;
               end
            end
         end

         ST_RUN: begin
            // A new pixel pushes the held one out, which needs a free slot.
            if (!(emit && hold_valid_ff && !slot_free)) begin
               if (emit && hold_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_col_in   = hold_col_ff;
                  out_row_in   = hold_row_ff;
                  out_color_in = hold_color_ff;
                  out_last_in  = 1'b0;
               end
               if (emit) begin
                  hold_valid_in = 1'b1;
                  hold_col_in   = cur_col_ff;
                  hold_row_in   = pix_row;
                  hold_color_in = bit_set ? fore_color_ff : back_color_ff;
               end
               bit_cnt_in    = bit_cnt_ff + BIT_IDX_BITS'(1);
               row_offset_in = offset_next;
               if (row_stop) begin
                  stopped_in = 1'b1;
                  state_in   = ST_FLUSH;
               end else if (col_wrap) begin
                  row_offset_in = '0;
                  cur_col_in    = col_next;
                  stopped_in    = col_stop;
                  state_in      = ST_FLUSH;
               end else if (bit_cnt_ff == '1) begin
                  state_in = ST_FLUSH;
               end
            end
         end

         ST_FLUSH: begin
            // Release the final pixel of the byte with its last flag.
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               out_valid_in  = 1'b1;
               out_col_in    = hold_col_ff;
               out_row_in    = hold_row_ff;
               out_color_in  = hold_color_ff;
               out_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bit_cnt_ff    <= '0;
         cur_col_ff    <= '0;
         origin_row_ff <= '0;
         row_offset_ff <= '0;
         stopped_ff    <= 1'b1;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bit_cnt_ff    <= bit_cnt_in;
         cur_col_ff    <= cur_col_in;
         origin_row_ff <= origin_row_in;
         row_offset_ff <= row_offset_in;
         stopped_ff    <= stopped_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      hold_col_ff   <= hold_col_in;
      hold_row_ff   <= hold_row_in;
      hold_color_ff <= hold_color_in;
      out_col_ff    <= out_col_in;
      out_row_ff    <= out_row_in;
      out_color_ff  <= out_color_in;
      out_last_ff   <= out_last_in;
   end

   // Pixel channel outputs.
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.pixel_col    = out_col_ff;
   assign rsp_chan.pixel_row    = out_row_ff;
   assign rsp_chan.pixel_color  = out_color_ff;
   assign rsp_chan.last_of_byte = out_last_ff;

endmodule
